// ----- src/ftms_pkg.sv -----
// ftms_pkg: widths, codes, event and phase types, timer and duty helpers
// shared by the force-triggered tapping motor sequencer modules
// no dependencies
`default_nettype none

package ftms_pkg;

  localparam int DUTY_BITS  = 10;
  localparam int TIMER_BITS = 16;

  localparam int RAW_W      = 24;
  localparam int TARE_W     = 25;
  localparam int FORCE_W    = 23;
  localparam int DUTY_OUT_W = 11;
  localparam int LIMIT_W    = 16;
  localparam int LIVE_W     = 28;
  localparam int PHASE_W    = 3;
  localparam int OPC_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  localparam int SAT_W  = (TIMER_BITS + 3 > LIMIT_W) ? TIMER_BITS + 3 : LIMIT_W;
  localparam int DUTY_W = (DUTY_BITS + 1 > DUTY_OUT_W) ? DUTY_BITS + 1 : DUTY_OUT_W;

  localparam logic [SAT_W-1:0]  TIMER_MAX_W = SAT_W'((64'd1 << TIMER_BITS) - 64'd1);
  localparam logic [DUTY_W-1:0] DUTY_MAX_W  = DUTY_W'(64'd1 << DUTY_BITS);

  localparam logic [RAW_W-1:0]  OFFSET_FLIP = RAW_W'(24'h800000);
  localparam logic [LIVE_W-1:0] ADC_ZERO    = LIVE_W'(8000000);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [OPC_W-1:0] OPC_SAMPLE = 2'd0;
  localparam logic [OPC_W-1:0] OPC_TICK   = 2'd1;
  localparam logic [OPC_W-1:0] OPC_EDGE   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TARE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_THR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CREEP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_DUTY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FWD_LIMIT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_REV_LIMIT = 3'd6;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE    = 3'd0,
    PH_SETTLE  = 3'd1,
    PH_WATCH   = 3'd2,
    PH_GAP     = 3'd3,
    PH_FULL    = 3'd4,
    PH_COAST   = 3'd5,
    PH_REVERSE = 3'd6,
    PH_PAUSE   = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    EV_SAMPLE = 2'd0,
    EV_TICK   = 2'd1,
    EV_EDGE   = 2'd2,
    EV_HOLD   = 2'd3
  } ev_kind_e;

  typedef struct packed {
    ev_kind_e kind;
    logic     pos;
    logic     neg;
    logic     above;
  } event_t;

  function automatic logic [TIMER_BITS-1:0] sat_timer(input logic [SAT_W-1:0] v);
    if (v > TIMER_MAX_W) begin
      return TIMER_MAX_W[TIMER_BITS-1:0];
    end
    return v[TIMER_BITS-1:0];
  endfunction

  function automatic logic [DUTY_OUT_W-1:0] clamp_duty(input logic [DUTY_OUT_W-1:0] d);
    logic [DUTY_W-1:0] dx;
    dx = DUTY_W'(d);
    if (dx > DUTY_MAX_W) begin
      return DUTY_MAX_W[DUTY_OUT_W-1:0];
    end
    return d;
  endfunction

  localparam logic [TIMER_BITS-1:0] SETTLE_T = sat_timer(SAT_W'(500));
  localparam logic [TIMER_BITS-1:0] COAST_T  = sat_timer(SAT_W'(100));
  localparam logic [TIMER_BITS-1:0] GAP_T    = sat_timer(SAT_W'(28));
  localparam logic [TIMER_BITS-1:0] PAUSE_T  = sat_timer(SAT_W'(400));
  localparam logic [TIMER_BITS-1:0] TIMER_MAX_T = TIMER_MAX_W[TIMER_BITS-1:0];

endpackage

`default_nettype wire

// ----- src/ftms_front.sv -----
// ftms_front: input stage; converts load samples to live force and
// classifies each event before it enters the queue. uses ftms_pkg
`default_nettype none

module ftms_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [ftms_pkg::OPC_W-1:0]      opcode_i,
  input  wire logic [ftms_pkg::RAW_W-1:0]      raw_sample_i,
  input  wire logic signed [ftms_pkg::TARE_W-1:0] tare_offset_i,
  input  wire logic [ftms_pkg::FORCE_W-1:0]    dead_band_i,
  input  wire logic [ftms_pkg::FORCE_W-1:0]    full_threshold_i,
  output logic                                 q_push_o,
  output ftms_pkg::event_t                     q_event_o,
  input  wire logic                            q_full_i
);
  import ftms_pkg::*;

  logic                     s1_valid_q, s1_valid_d;
  ev_kind_e                 s1_kind_q, kind_dec;
  logic signed [LIVE_W-1:0] s1_live_q, live_d;
  logic [RAW_W-1:0]         flipped;
  logic                     accept;

  assign in_ready_o = !s1_valid_q || !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign q_push_o   = s1_valid_q && !q_full_i;
  assign s1_valid_d = accept ? 1'b1 : (q_push_o ? 1'b0 : s1_valid_q);

  assign flipped = raw_sample_i ^ OFFSET_FLIP;
  assign live_d  = $signed(LIVE_W'(flipped)) - $signed(ADC_ZERO)
                   - LIVE_W'(tare_offset_i) - $signed(LIVE_W'(dead_band_i));

  always_comb begin
    unique case (opcode_i)
      OPC_SAMPLE: kind_dec = EV_SAMPLE;
      OPC_TICK:   kind_dec = EV_TICK;
      OPC_EDGE:   kind_dec = EV_EDGE;
      default:    kind_dec = EV_HOLD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_kind_q <= kind_dec;
      s1_live_q <= live_d;
    end
  end

  // sign tests and threshold compare on the registered force
  always_comb begin
    q_event_o.kind  = s1_kind_q;
    q_event_o.neg   = s1_live_q[LIVE_W-1];
    q_event_o.pos   = !s1_live_q[LIVE_W-1] && (s1_live_q != '0);
    q_event_o.above = s1_live_q > $signed(LIVE_W'(full_threshold_i));
  end

endmodule

`default_nettype wire

// ----- src/ftms_queue.sv -----
// ftms_queue: short flop-based event queue between front and back
// uses ftms_pkg
`default_nettype none

module ftms_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  ftms_pkg::event_t      event_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output ftms_pkg::event_t      event_o
);
  import ftms_pkg::*;

  event_t              entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]     count_q;

  assign full_o  = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign event_o = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= event_i;
    end
  end

endmodule

`default_nettype wire

// ----- src/ftms_back.sv -----
// ftms_back: phase sequencer; executes queued events and holds the
// result register. uses ftms_pkg
`default_nettype none

module ftms_back (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              q_empty_i,
  input  ftms_pkg::event_t                       q_event_i,
  output logic                                   q_pop_o,
  input  wire logic [ftms_pkg::DUTY_OUT_W-1:0]   creep_duty_i,
  input  wire logic [ftms_pkg::DUTY_OUT_W-1:0]   full_duty_i,
  input  wire logic [ftms_pkg::LIMIT_W-1:0]      fwd_limit_i,
  input  wire logic [ftms_pkg::LIMIT_W-1:0]      rev_limit_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [ftms_pkg::DUTY_OUT_W-1:0]        drive_forward_o,
  output logic [ftms_pkg::DUTY_OUT_W-1:0]        drive_reverse_o,
  output logic [ftms_pkg::PHASE_W-1:0]           phase_o
);
  import ftms_pkg::*;

  phase_e                  phase_q, phase_d;
  logic [TIMER_BITS-1:0]   cd_q, cd_d, fe_q, fe_d, rev_len_q, rev_len_d;
  logic                    edge_q, edge_d, out_valid_q, out_valid_d;
  logic [DUTY_OUT_W-1:0]   fwd_q, fwd_d, rev_q, rev_d;
  logic [TIMER_BITS-1:0]   full_load, cd_dec, fe_inc;
  logic [SAT_W-1:0]        rev_scaled, rev_min;

  assign q_pop_o     = !q_empty_i && (!out_valid_q || out_ready_i);
  assign out_valid_d = q_pop_o ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  assign out_valid_o     = out_valid_q;
  assign drive_forward_o = fwd_q;
  assign drive_reverse_o = rev_q;
  assign phase_o         = phase_q;

  // reverse length from frozen forward time: min(limit, elapsed*10/8)
  assign rev_scaled = (SAT_W'(fe_q) + (SAT_W'(fe_q) << 2)) >> 2;
  assign rev_min    = (rev_scaled < SAT_W'(rev_limit_i)) ? rev_scaled : SAT_W'(rev_limit_i);
  assign rev_len_d  = sat_timer(rev_min);

  assign full_load = sat_timer(SAT_W'(fwd_limit_i));
  assign cd_dec    = (cd_q != '0) ? cd_q - 1'b1 : cd_q;
  assign fe_inc    = (fe_q != TIMER_MAX_T) ? fe_q + 1'b1 : fe_q;

  always_comb begin
    phase_d = phase_q;
    cd_d    = cd_q;
    fe_d    = fe_q;
    edge_d  = edge_q;
    fwd_d   = fwd_q;
    rev_d   = rev_q;
    if (q_pop_o) begin
      unique case (q_event_i.kind)
        EV_SAMPLE: begin
          if (phase_q == PH_IDLE) begin
            if (q_event_i.pos) begin
              fwd_d   = clamp_duty(creep_duty_i);
              rev_d   = '0;
              phase_d = PH_SETTLE;
              cd_d    = SETTLE_T;
            end
          end else if (phase_q == PH_WATCH) begin
            if (q_event_i.neg) begin
              fwd_d   = '0;
              phase_d = PH_IDLE;
            end else if (q_event_i.above) begin
              fe_d = '0;
              if (edge_q || (full_load == '0)) begin
                edge_d  = 1'b0;
                fwd_d   = '0;
                phase_d = PH_COAST;
                cd_d    = COAST_T;
              end else begin
                fwd_d   = clamp_duty(full_duty_i);
                phase_d = PH_FULL;
                cd_d    = full_load;
              end
            end else begin
              phase_d = PH_GAP;
              cd_d    = GAP_T;
            end
          end
        end
        EV_TICK: begin
          if (phase_q != PH_IDLE && phase_q != PH_WATCH) begin
            if (phase_q == PH_FULL) begin
              fe_d = fe_inc;
            end
            cd_d = cd_dec;
            if (cd_dec == '0) begin
              unique case (phase_q) inside
                PH_SETTLE, PH_GAP: phase_d = PH_WATCH;
                PH_FULL: begin
                  fwd_d   = '0;
                  phase_d = PH_COAST;
                  cd_d    = COAST_T;
                end
                PH_COAST: begin
                  if (rev_len_q == '0) begin
                    rev_d   = '0;
                    phase_d = PH_PAUSE;
                    cd_d    = PAUSE_T;
                  end else begin
                    rev_d   = clamp_duty(full_duty_i);
                    phase_d = PH_REVERSE;
                    cd_d    = rev_len_q;
                  end
                end
                PH_REVERSE: begin
                  rev_d   = '0;
                  phase_d = PH_PAUSE;
                  cd_d    = PAUSE_T;
                end
                default: phase_d = PH_IDLE;
              endcase
            end
          end
        end
        EV_EDGE: begin
          if (phase_q == PH_FULL) begin
            edge_d  = 1'b0;
            fwd_d   = '0;
            phase_d = PH_COAST;
            cd_d    = COAST_T;
          end else begin
            edge_d = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      cd_q        <= '0;
      fe_q        <= '0;
      edge_q      <= 1'b0;
      fwd_q       <= '0;
      rev_q       <= '0;
      out_valid_q <= 1'b0;
      rev_len_q   <= '0;
    end else begin
      phase_q     <= phase_d;
      cd_q        <= cd_d;
      fe_q        <= fe_d;
      edge_q      <= edge_d;
      fwd_q       <= fwd_d;
      rev_q       <= rev_d;
      out_valid_q <= out_valid_d;
      rev_len_q   <= rev_len_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/force_triggered_tapping_motor_sequencer_core.sv -----
// force_triggered_tapping_motor_sequencer_core: top level with config registers,
// front stage, event queue and phase sequencer. uses ftms_pkg, ftms_front,
// ftms_queue, ftms_back
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-----------------------------------------
//   in       | in_valid_i/in_ready_o | opcode_i, raw_sample_i
//   out      | out_valid_o/out_ready_i | drive_forward_o, drive_reverse_o, phase_o
//   cfg      | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// one event per cycle sustained while out_ready_i is held high; an input transfer is registered
// in the force subtract stage, then written into the queue, then loads the sequencer result register
// the 4-entry queue lets the input side keep going while a result waits
// reset puts the sequencer in idle with zero drive and registers at defaults
`default_nettype none

module force_triggered_tapping_motor_sequencer_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [ftms_pkg::OPC_W-1:0]        opcode_i,
  input  wire logic [ftms_pkg::RAW_W-1:0]        raw_sample_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [ftms_pkg::DUTY_OUT_W-1:0]        drive_forward_o,
  output logic [ftms_pkg::DUTY_OUT_W-1:0]        drive_reverse_o,
  output logic [ftms_pkg::PHASE_W-1:0]           phase_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [ftms_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [ftms_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import ftms_pkg::*;

  logic signed [TARE_W-1:0] tare_q;
  logic [FORCE_W-1:0]       dead_band_q, full_thr_q;
  logic [DUTY_OUT_W-1:0]    creep_q, full_duty_q;
  logic [LIMIT_W-1:0]       fwd_limit_q, rev_limit_q;

  logic   q_push, q_full, q_pop, q_empty;
  event_t push_event, pop_event;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tare_q      <= '0;
      dead_band_q <= FORCE_W'(10000);
      full_thr_q  <= FORCE_W'(25000);
      creep_q     <= DUTY_OUT_W'(1 << 5);
      full_duty_q <= DUTY_MAX_W[DUTY_OUT_W-1:0];
      fwd_limit_q <= LIMIT_W'(39 * 8);
      rev_limit_q <= LIMIT_W'(39 * 10);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TARE:      tare_q      <= $signed(cfg_data_i[TARE_W-1:0]);
        CFG_DEAD_BAND: dead_band_q <= cfg_data_i[FORCE_W-1:0];
        CFG_FULL_THR:  full_thr_q  <= cfg_data_i[FORCE_W-1:0];
        CFG_CREEP:     creep_q     <= cfg_data_i[DUTY_OUT_W-1:0];
        CFG_FULL_DUTY: full_duty_q <= cfg_data_i[DUTY_OUT_W-1:0];
        CFG_FWD_LIMIT: fwd_limit_q <= cfg_data_i[LIMIT_W-1:0];
        CFG_REV_LIMIT: rev_limit_q <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  ftms_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .raw_sample_i     (raw_sample_i),
    .tare_offset_i    (tare_q),
    .dead_band_i      (dead_band_q),
    .full_threshold_i (full_thr_q),
    .q_push_o         (q_push),
    .q_event_o        (push_event),
    .q_full_i         (q_full)
  );

  ftms_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .event_i (push_event),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .event_o (pop_event)
  );

  ftms_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_event_i       (pop_event),
    .q_pop_o         (q_pop),
    .creep_duty_i    (creep_q),
    .full_duty_i     (full_duty_q),
    .fwd_limit_i     (fwd_limit_q),
    .rev_limit_i     (rev_limit_q),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .drive_forward_o (drive_forward_o),
    .drive_reverse_o (drive_reverse_o),
    .phase_o         (phase_o)
  );

endmodule

`default_nettype wire

// ----- tb/tb_force_triggered_tapping_motor_sequencer_core.sv -----
`timescale 1ns / 1ps
// tb_force_triggered_tapping_motor_sequencer_core: self-checking bench for the tapping motor
// sequencer core, with its own prediction of the phase machine and an in-order scoreboard
// depends on ftms_pkg and force_triggered_tapping_motor_sequencer_core

module tb_force_triggered_tapping_motor_sequencer_core;
  import ftms_pkg::*;

  localparam int          TW            = TIMER_BITS;
  localparam longint      TIMER_TOP     = (64'sd1 <<< TIMER_BITS) - 1;
  localparam logic [10:0] DUTY_TOP      = 11'(1 << DUTY_BITS);
  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  localparam logic [23:0] RAW_FLIP      = 24'h800000;
  localparam longint      ADC_OFFSET    = 8000000;
  localparam longint      SETTLE_TICKS  = 500;
  localparam longint      COAST_TICKS   = 100;
  localparam longint      GAP_TICKS     = 28;
  localparam longint      PAUSE_TICKS   = 400;
  localparam longint      REV_SCALE_DEN = 8;
  localparam longint      REV_SCALE_NUM = 10;
  localparam logic [24:0] TARE_MAX      = 25'd8777215;
  localparam logic [24:0] TARE_MIN      = 25'(-8000000);
  localparam int          STALL_LIMIT   = 1000;
  localparam int          SETTINGS_RUN  = 4;
  localparam int          EVENTS_PER    = 360;

  typedef struct packed {
    logic [10:0] fwd;
    logic [10:0] rev;
    phase_e      ph;
  } drive_t;

  typedef struct packed {
    logic        cfg_en;
    logic [2:0]  cfg_idx;
    logic [24:0] cfg_val;
    logic [1:0]  op;
    logic [23:0] raw;
    logic        typed;
    drive_t      want;
  } probe_row_t;

  localparam drive_t IDLE_OFF    = '{11'd0, 11'd0, PH_IDLE};
  localparam drive_t CREEP_RESET = '{11'd32, 11'd0, PH_SETTLE};

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_ready_o;
  logic [1:0]  opcode_i        = 2'd0;
  logic [23:0] raw_sample_i    = 24'd0;
  logic        out_valid_o;
  logic        out_ready_i     = 1'b0;
  logic [10:0] drive_forward_o;
  logic [10:0] drive_reverse_o;
  logic [2:0]  phase_o;
  logic        cfg_we_i        = 1'b0;
  logic [2:0]  cfg_idx_i       = 3'd0;
  logic [24:0] cfg_data_i      = 25'd0;

  // shadow of the configuration registers
  logic signed [24:0] tare         = '0;
  logic [22:0]        dead_band    = 23'd10000;
  logic [22:0]        full_thr     = 23'd25000;
  logic [10:0]        creep_duty   = 11'd32;
  logic [10:0]        full_duty    = 11'd1024;
  logic [15:0]        fwd_limit    = 16'd312;
  logic [15:0]        rev_limit    = 16'd390;

  // predicted sequencer state
  phase_e      seq_phase   = PH_IDLE;
  logic [TW-1:0] timer_left  = '0;
  logic [TW-1:0] fwd_elapsed = '0;
  logic        edge_held   = 1'b0;
  logic [10:0] fwd_duty    = '0;
  logic [10:0] rev_duty    = '0;

  drive_t drive_q[$];
  int     mismatches   = 0;
  int     counted      = 0;
  int     stall_cycles = 0;
  bit     send_burst   = 1'b0;
  bit     take_burst   = 1'b0;

  probe_row_t probes [14] = '{
    '{1'b0, CFG_TARE, 25'd0,    OP_UNUSED,  24'hFFFFFF, 1'b1, IDLE_OFF},
    '{1'b0, CFG_TARE, 25'd0,    OPC_TICK,   24'h000000, 1'b1, IDLE_OFF},
    '{1'b0, CFG_TARE, 25'd0,    OPC_SAMPLE, 24'hFA3910, 1'b1, IDLE_OFF},
    '{1'b0, CFG_TARE, 25'd0,    OPC_SAMPLE, 24'h800000, 1'b1, IDLE_OFF},
    '{1'b1, CFG_TARE, TARE_MAX, OPC_SAMPLE, 24'h7FFFFF, 1'b1, IDLE_OFF},
    '{1'b1, CFG_TARE, TARE_MIN, OPC_SAMPLE, 24'h800000, 1'b1, IDLE_OFF},
    '{1'b0, CFG_TARE, 25'd0,    OPC_EDGE,   24'h000000, 1'b1, IDLE_OFF},
    '{1'b1, CFG_TARE, 25'd0,    OPC_SAMPLE, 24'hFA3911, 1'b1, CREEP_RESET},
    '{1'b0, CFG_TARE, 25'd0,    OPC_EDGE,   24'hFFFFFF, 1'b1, CREEP_RESET},
    '{1'b0, CFG_TARE, 25'd0,    OPC_SAMPLE, 24'hFFFFFF, 1'b1, CREEP_RESET},
    '{1'b0, CFG_TARE, 25'd0,    OPC_TICK,   24'h5A5A5A, 1'b0, '0},
    '{1'b0, CFG_TARE, 25'd0,    OP_UNUSED,  24'h000000, 1'b0, '0},
    '{1'b0, CFG_TARE, 25'd0,    OPC_EDGE,   24'hA5A5A5, 1'b0, '0},
    '{1'b0, CFG_TARE, 25'd0,    OPC_SAMPLE, 24'h000000, 1'b0, '0}
  };

  force_triggered_tapping_motor_sequencer_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .raw_sample_i    (raw_sample_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .drive_forward_o (drive_forward_o),
    .drive_reverse_o (drive_reverse_o),
    .phase_o         (phase_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [10:0] clip_duty(input logic [10:0] d);
    return (d > DUTY_TOP) ? DUTY_TOP : d;
  endfunction

  function automatic logic [TW-1:0] sat_ticks(input longint v);
    return (v > TIMER_TOP) ? TW'(TIMER_TOP) : TW'(v);
  endfunction

  function automatic void start_coast();
    fwd_duty   = '0;
    seq_phase  = PH_COAST;
    timer_left = sat_ticks(COAST_TICKS);
  endfunction

  function automatic void start_pause();
    rev_duty   = '0;
    seq_phase  = PH_PAUSE;
    timer_left = sat_ticks(PAUSE_TICKS);
  endfunction

  // raw word whose force lands on the target, clipped to the converter range
  function automatic logic [23:0] raw_for(input longint target);
    longint v;
    v = target + ADC_OFFSET + longint'(tare) + longint'(dead_band);
    if (v < 0) begin
      v = 0;
    end else if (v > 16777215) begin
      v = 16777215;
    end
    return v[23:0] ^ RAW_FLIP;
  endfunction

  function automatic drive_t advance_sequencer(input logic [1:0] op, input logic [23:0] raw);
    longint live;
    longint span;
    drive_t now;
    live = longint'(raw ^ RAW_FLIP) - ADC_OFFSET - longint'(tare) - longint'(dead_band);
    case (op)
      OPC_SAMPLE: begin
        if (seq_phase == PH_IDLE) begin
          if (live > 0) begin
            fwd_duty   = clip_duty(creep_duty);
            rev_duty   = '0;
            seq_phase  = PH_SETTLE;
            timer_left = sat_ticks(SETTLE_TICKS);
          end
        end else if (seq_phase == PH_WATCH) begin
          // negative force wins over full
          if (live < 0) begin
            fwd_duty  = '0;
            seq_phase = PH_IDLE;
          end else if (live > longint'(full_thr)) begin
            fwd_duty    = clip_duty(full_duty);
            fwd_elapsed = '0;
            seq_phase   = PH_FULL;
            timer_left  = sat_ticks(longint'(fwd_limit));
            if (edge_held || timer_left == 0) begin
              edge_held = 1'b0;
              start_coast();
            end
          end else begin
            seq_phase  = PH_GAP;
            timer_left = sat_ticks(GAP_TICKS);
          end
        end
      end
      OPC_TICK: begin
        if (seq_phase != PH_IDLE && seq_phase != PH_WATCH) begin
          if (seq_phase == PH_FULL && fwd_elapsed != TW'(TIMER_TOP)) fwd_elapsed++;
          if (timer_left != 0) timer_left--;
          if (timer_left == 0) begin
            case (seq_phase) inside
              PH_SETTLE, PH_GAP: seq_phase = PH_WATCH;
              PH_FULL: start_coast();
              PH_COAST: begin
                span = longint'(fwd_elapsed) * REV_SCALE_NUM / REV_SCALE_DEN;
                if (span > longint'(rev_limit)) span = longint'(rev_limit);
                if (sat_ticks(span) == 0) begin
                  start_pause();
                end else begin
                  rev_duty   = clip_duty(full_duty);
                  seq_phase  = PH_REVERSE;
                  timer_left = sat_ticks(span);
                end
              end
              PH_REVERSE: start_pause();
              default: seq_phase = PH_IDLE;
            endcase
          end
        end
      end
      OPC_EDGE: begin
        if (seq_phase == PH_FULL) begin
          edge_held = 1'b0;
          start_coast();
        end else begin
          edge_held = 1'b1;
        end
      end
      default: ;
    endcase
    now.fwd = fwd_duty;
    now.rev = rev_duty;
    now.ph  = seq_phase;
    return now;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 200) $display("%0t: %s got %0d want %0d", $time, what, got, want);
  endtask

  task automatic send_event(input logic [1:0] op, input logic [23:0] raw, input logic typed,
                            input drive_t want);
    int     gap;
    drive_t got;
    gap = send_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      if (in_valid_i) in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    raw_sample_i <= raw;
    do @(posedge clk_i); while (!in_ready_o);
    counted++;
    got = advance_sequencer(op, raw);
    drive_q.push_back(typed ? want : got);
  endtask

  task automatic drain();
    if (in_valid_i) in_valid_i <= 1'b0;
    do @(posedge clk_i); while (drive_q.size() != 0);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [24:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_TARE:      tare       = data;
      CFG_DEAD_BAND: dead_band  = data[22:0];
      CFG_FULL_THR:  full_thr   = data[22:0];
      CFG_CREEP:     creep_duty = data[10:0];
      CFG_FULL_DUTY: full_duty  = data[10:0];
      CFG_FWD_LIMIT: fwd_limit  = data[15:0];
      CFG_REV_LIMIT: rev_limit  = data[15:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(input int sel);
    int tr, db, th, cd, fd, fl, rl;
    tr = int'($urandom_range(0, 100000)) - 50000;
    db = $urandom_range(0, 30000);
    th = $urandom_range(0, 60000);
    cd = $urandom_range(0, 1024);
    fd = $urandom_range(0, 1024);
    fl = $urandom_range(1, 30);
    rl = $urandom_range(1, 20);
    case (sel)
      // no forward time, reverse bounded only by elapsed, duties over range
      0: begin
        db = 0;
        th = 0;
        cd = 2047;
        fd = 2047;
        fl = 0;
        rl = 65535;
      end
      // reverse always skipped
      1: rl = 0;
      // full ends only on a proximity edge
      2: begin
        cd = 1024;
        fd = 1024;
        fl = 65535;
      end
      // widest tare and band, full only at the top of the range
      default: begin
        tr = -8000000;
        db = 8388607;
        th = 8388607;
        cd = 0;
        fd = $urandom_range(0, 2047);
        fl = $urandom_range(5, 40);
        rl = 65535;
      end
    endcase
    drain();
    put_reg(CFG_TARE, 25'(tr));
    put_reg(CFG_DEAD_BAND, 25'(db));
    put_reg(CFG_FULL_THR, 25'(th));
    put_reg(CFG_CREEP, 25'(cd));
    put_reg(CFG_FULL_DUTY, 25'(fd));
    put_reg(CFG_FWD_LIMIT, 25'(fl));
    put_reg(CFG_REV_LIMIT, 25'(rl));
    cfg_we_i <= 1'b0;
  endtask

  // mostly steers the sequence forward, with some noise mixed in
  task automatic send_random();
    int          r;
    logic [1:0]  op;
    logic [23:0] raw;
    longint      aim;
    r   = $urandom_range(0, 999);
    raw = 24'($urandom);
    op  = OPC_TICK;
    if (r < 4 || (seq_phase == PH_FULL && r < 70)) begin
      op = OPC_EDGE;
    end else if (r < 30) begin
      op = OP_UNUSED;
    end else if (r < 80) begin
      op = OPC_SAMPLE;
    end else if (seq_phase == PH_IDLE) begin
      if (r < 650) begin
        op  = OPC_SAMPLE;
        raw = raw_for(longint'($urandom_range(1, 100000)));
      end
    end else if (seq_phase == PH_WATCH) begin
      if (r < 300) begin
        aim = -longint'($urandom_range(1, 100000));
      end else if (r < 600) begin
        aim = longint'(full_thr) + longint'($urandom_range(1, 100000));
      end else if (r < 900) begin
        aim = longint'($urandom_range(0, full_thr));
      end else if (r < 925) begin
        aim = 0;
      end else begin
        aim = longint'(full_thr);
      end
      if (r < 950) begin
        op  = OPC_SAMPLE;
        raw = raw_for(aim);
      end
    end
    send_event(op, raw, 1'b0, '0);
  endtask

  initial begin
    int quota;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (probes[i]) begin
      if (probes[i].cfg_en) begin
        drain();
        put_reg(probes[i].cfg_idx, probes[i].cfg_val);
        cfg_we_i <= 1'b0;
      end
      send_event(probes[i].op, probes[i].raw, probes[i].typed, probes[i].want);
    end

    for (int sel = 0; sel < SETTINGS_RUN; sel++) begin
      load_setting(sel);
      quota = counted + EVENTS_PER;
      while (counted < quota) begin
        if ($urandom_range(0, 63) == 0) send_burst = ~send_burst;
        if ($urandom_range(0, 299) == 0) drain();
        send_random();
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    int stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 63) == 0) take_burst = ~take_burst;
      stall = take_burst ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        if (out_ready_i) out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  always @(posedge clk_i) begin
    drive_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (drive_q.size() == 0) begin
        report_mismatch("result transfer with nothing expected, phase", int'(phase_o), 0);
      end else begin
        want = drive_q.pop_front();
        if (drive_forward_o !== want.fwd) begin
          report_mismatch("drive_forward", int'(drive_forward_o), int'(want.fwd));
        end
        if (drive_reverse_o !== want.rev) begin
          report_mismatch("drive_reverse", int'(drive_reverse_o), int'(want.rev));
        end
        if (phase_o !== want.ph) report_mismatch("phase", int'(phase_o), int'(want.ph));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

endmodule
